// ===== rtl/core/rkt_pkg.sv =====
`default_nettype none

package rkt_pkg;

    localparam int KEY_W     = 32;
    localparam int CMD_W     = 2;
    localparam int REF_CNT_W = 16;
    localparam int USED_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    // result of one command, handed from the sequencer to the output stage
    typedef struct packed {
        logic                 present;
        t_status              status;
        logic [REF_CNT_W-1:0] ref_cnt;
    } t_res;

    // occupancy adjustment requested by the sequencer
    typedef struct packed {
        logic inc;
        logic dec;
    } t_occ_upd;

endpackage

`default_nettype wire

// ===== rtl/core/rkt_store.sv =====
`default_nettype none

module rkt_store #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [IDX_W-1:0]            i_rd_addr,
    output logic [rkt_pkg::KEY_W-1:0]        o_rd_key,
    output logic [COUNT_BITS-1:0]            o_rd_cnt,
    output logic                             o_rd_valid,
    input  wire logic                        i_wr_en,
    input  wire logic [IDX_W-1:0]            i_wr_addr,
    input  wire logic [rkt_pkg::KEY_W-1:0]   i_wr_key,
    input  wire logic [COUNT_BITS-1:0]       i_wr_cnt,
    input  wire logic                        i_vld_we,
    input  wire logic                        i_vld_val
);

    logic [rkt_pkg::KEY_W-1:0] r_key_mem [ENTRIES];
    logic [COUNT_BITS-1:0]     r_cnt_mem [ENTRIES];
    logic [ENTRIES-1:0]        r_valid;
    logic [rkt_pkg::KEY_W-1:0] r_rd_key;
    logic [COUNT_BITS-1:0]     r_rd_cnt;
    logic                      r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
            r_cnt_mem[i_wr_addr] <= i_wr_cnt;
        end
        r_rd_key <= r_key_mem[i_rd_addr];
        r_rd_cnt <= r_cnt_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_vld_we) begin
                r_valid[i_wr_addr] <= i_vld_val;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_cnt   = r_rd_cnt;
    assign o_rd_valid = r_rd_valid;

endmodule

`default_nettype wire

// ===== rtl/core/rkt_ctrl.sv =====
`default_nettype none

module rkt_ctrl #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [rkt_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [rkt_pkg::KEY_W-1:0]   i_key,
    output logic [IDX_W-1:0]                 o_rd_addr,
    input  wire logic [rkt_pkg::KEY_W-1:0]   i_rd_key,
    input  wire logic [COUNT_BITS-1:0]       i_rd_cnt,
    input  wire logic                        i_rd_valid,
    output logic                             o_wr_en,
    output logic [IDX_W-1:0]                 o_wr_addr,
    output logic [rkt_pkg::KEY_W-1:0]        o_wr_key,
    output logic [COUNT_BITS-1:0]            o_wr_cnt,
    output logic                             o_vld_we,
    output logic                             o_vld_val,
    output rkt_pkg::t_occ_upd                o_occ,
    output logic                             o_res_valid,
    output rkt_pkg::t_res                    o_res,
    input  wire logic                        i_res_take
);

    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_UPD  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    rkt_pkg::t_cmd             r_cmd;
    logic [rkt_pkg::KEY_W-1:0] r_key;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_issued_all;
    logic                      r_pv;
    logic [IDX_W-1:0]          r_pidx;
    logic                      r_hit;
    logic [IDX_W-1:0]          r_hit_idx;
    logic [COUNT_BITS-1:0]     r_hit_cnt;
    logic                      r_free_found;
    logic [IDX_W-1:0]          r_free_idx;
    rkt_pkg::t_res             r_res, n_res;

    logic                      accept;
    logic                      issuing;
    logic                      match;
    logic                      last_chk;
    logic                      cnt_dec;
    logic [COUNT_BITS-1:0]     cnt_adj;
    logic                      cnt_at_max;
    logic                      cnt_le1;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign issuing    = (r_state == S_SCAN) && !r_issued_all;
    assign match      = (r_state == S_SCAN) && r_pv && i_rd_valid && (i_rd_key == r_key);
    assign last_chk   = (r_state == S_SCAN) && r_pv && (r_pidx == LAST_IDX);
    assign o_rd_addr  = r_idx;

    // one adder serves both acquire and release
    assign cnt_dec    = (r_cmd == rkt_pkg::CMD_RELEASE);
    assign cnt_adj    = r_hit_cnt + (cnt_dec ? COUNT_MAX : COUNT_ONE);
    assign cnt_at_max = (r_hit_cnt == COUNT_MAX);
    assign cnt_le1    = ((r_hit_cnt >> 1) == '0);

    always_comb begin
        n_state           = r_state;
        n_res             = r_res;
        o_wr_en           = 1'b0;
        o_wr_addr         = r_hit ? r_hit_idx : r_free_idx;
        o_wr_key          = r_key;
        o_wr_cnt          = cnt_adj;
        o_vld_we          = 1'b0;
        o_vld_val         = 1'b0;
        o_occ             = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (match || last_chk) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state         = S_EMIT;
                n_res.present   = 1'b0;
                n_res.status    = rkt_pkg::ST_OK;
                n_res.ref_cnt   = '0;
                unique case (r_cmd)
                    rkt_pkg::CMD_ACQUIRE: begin
                        if (r_hit) begin
                            n_res.present = 1'b1;
                            if (cnt_at_max) begin
                                n_res.status  = rkt_pkg::ST_SAT;
                                n_res.ref_cnt = rkt_pkg::REF_CNT_W'(r_hit_cnt);
                            end else begin
                                o_wr_en       = 1'b1;
                                n_res.ref_cnt = rkt_pkg::REF_CNT_W'(cnt_adj);
                            end
                        end else if (r_free_found) begin
                            o_wr_en         = 1'b1;
                            o_wr_cnt        = COUNT_ONE;
                            o_vld_we        = 1'b1;
                            o_vld_val       = 1'b1;
                            o_occ.inc       = 1'b1;
                            n_res.present   = 1'b1;
                            n_res.ref_cnt   = rkt_pkg::REF_CNT_W'(COUNT_ONE);
                        end else begin
                            n_res.status = rkt_pkg::ST_FULL;
                        end
                    end
                    rkt_pkg::CMD_RELEASE: begin
                        if (!r_hit) begin
                            n_res.status = rkt_pkg::ST_MISS;
                        end else if (cnt_le1) begin
                            // last reference gone: slot is freed
                            o_vld_we  = 1'b1;
                            o_occ.dec = 1'b1;
                        end else begin
                            o_wr_en         = 1'b1;
                            n_res.present   = 1'b1;
                            n_res.ref_cnt   = rkt_pkg::REF_CNT_W'(cnt_adj);
                        end
                    end
                    default: begin
                        // query, and the unused code, only look
                        if (r_hit) begin
                            n_res.present   = 1'b1;
                            n_res.ref_cnt   = rkt_pkg::REF_CNT_W'(r_hit_cnt);
                        end else begin
                            n_res.status = rkt_pkg::ST_MISS;
                        end
                    end
                endcase
            end
            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issued_all <= 1'b0;
            r_pv         <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= issuing;
            if (accept) begin
                r_idx        <= '0;
                r_issued_all <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (issuing) begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == LAST_IDX) begin
                        r_issued_all <= 1'b1;
                    end
                end
                if (match) begin
                    r_hit <= 1'b1;
                end
                // slots are checked in order, so the first empty one is the lowest
                if ((r_state == S_SCAN) && r_pv && !i_rd_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_pidx <= r_idx;
        if (accept) begin
            r_cmd <= rkt_pkg::t_cmd'(i_cmd);
            r_key <= i_key;
        end
        if (match) begin
            r_hit_idx <= r_pidx;
            r_hit_cnt <= i_rd_cnt;
        end
        if ((r_state == S_SCAN) && r_pv && !i_rd_valid && !r_free_found) begin
            r_free_idx <= r_pidx;
        end
    end

    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;

    a_write_in_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en || o_vld_we) |-> (r_state == S_UPD))
        else $error("store written outside the update step");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN))
        else $error("accepted beat did not start a scan");

    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld_we && o_vld_val) |-> (!r_hit && r_free_found))
        else $error("insert without a free slot or on a hit");

endmodule

`default_nettype wire

// ===== rtl/core/refcounted_key_table.sv =====
`default_nettype none

// Reference-counted key table of ENTRIES slots. Each command (acquire, release,
// query) returns one result beat with presence, status, count and slot usage.
// A command walks the slots up to the one that holds its key, or all ENTRIES
// slots when the key is absent (every acquire that inserts or finds the table
// full, and every miss): the slots are walked one per cycle through a single
// key comparator on the key store's registered read port, then an update step
// writes the slot back and the result moves to the output register. The next
// command is taken as soon as the result has left the sequencer, even while
// the output register still waits on i_out_ready. Valid bits clear at reset;
// no clearing pass is needed.
module refcounted_key_table #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [rkt_pkg::CMD_W-1:0]         i_cmd,
    input  wire logic [rkt_pkg::KEY_W-1:0]         i_key,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_present,
    output logic [1:0]                             o_status,
    output logic [rkt_pkg::REF_CNT_W-1:0]          o_ref_cnt,
    output logic [rkt_pkg::USED_W-1:0]             o_used_entries
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);

    logic [IDX_W-1:0]                rd_addr;
    logic [rkt_pkg::KEY_W-1:0]       rd_key;
    logic [COUNT_BITS-1:0]           rd_cnt;
    logic                            rd_valid;
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [rkt_pkg::KEY_W-1:0]       wr_key;
    logic [COUNT_BITS-1:0]           wr_cnt;
    logic                            vld_we;
    logic                            vld_val;
    rkt_pkg::t_occ_upd               occ_upd;
    logic                            res_valid;
    rkt_pkg::t_res                   res;
    logic                            res_take;

    logic [OCC_W-1:0]                r_occ;
    logic                            r_out_valid;
    logic                            r_present;
    logic [1:0]                      r_status;
    logic [rkt_pkg::REF_CNT_W-1:0]   r_ref_cnt;
    logic [rkt_pkg::USED_W-1:0]      r_used;

    rkt_store #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (rd_key),
        .o_rd_cnt   (rd_cnt),
        .o_rd_valid (rd_valid),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (wr_key),
        .i_wr_cnt   (wr_cnt),
        .i_vld_we   (vld_we),
        .i_vld_val  (vld_val)
    );

    rkt_ctrl #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_key       (i_key),
        .o_rd_addr   (rd_addr),
        .i_rd_key    (rd_key),
        .i_rd_cnt    (rd_cnt),
        .i_rd_valid  (rd_valid),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_key    (wr_key),
        .o_wr_cnt    (wr_cnt),
        .o_vld_we    (vld_we),
        .o_vld_val   (vld_val),
        .o_occ       (occ_upd),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // output register frees up when empty or when its beat is taken
    assign res_take = res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (occ_upd.inc) begin
                r_occ <= r_occ + OCC_W'(1);
            end else if (occ_upd.dec) begin
                r_occ <= r_occ - OCC_W'(1);
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_present <= res.present;
            r_status  <= res.status;
            r_ref_cnt <= res.ref_cnt;
            r_used    <= rkt_pkg::USED_W'(r_occ);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_present      = r_present;
    assign o_status       = r_status;
    assign o_ref_cnt      = r_ref_cnt;
    assign o_used_entries = r_used;

    a_occ_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ_upd.inc |-> (r_occ < OCC_W'(ENTRIES)))
        else $error("insert with every slot already used");

    a_occ_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ_upd.dec |-> (r_occ != '0))
        else $error("slot freed with no slot in use");

    a_occ_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(occ_upd.inc && occ_upd.dec))
        else $error("occupancy raised and lowered together");

endmodule

`default_nettype wire
